FILE: design/wtb64_pkg.sv
package wtb64_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_kind;
    logic [1:0] end_status;
    logic       final_item;
  } out_item_t;

  // Work handed from the front part to the back part through the queue.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] raw_byte;
    logic       has_end;
    logic [1:0] end_status;
  } job_t;

  localparam int DigestBytesDefault = 20;
  localparam int QueueDepth = 4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_MARKER  = 2'd1;
  localparam logic [1:0] ST_NO_TERM    = 2'd2;
  localparam logic [1:0] ST_SHORT      = 2'd3;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [6:0] {
    PH_KEYWORD = 7'b0000001,
    PH_SPACE   = 7'b0000010,
    PH_MARKER  = 7'b0000100,
    PH_FAILED  = 7'b0001000,
    PH_LINES   = 7'b0010000,
    PH_DECODE  = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef enum logic [5:0] {
    LC_FIRST_EMPTY  = 6'b000001,
    LC_FIRST        = 6'b000010,
    LC_SECOND_EMPTY = 6'b000100,
    LC_SECOND       = 6'b001000,
    LC_TRAIL        = 6'b010000,
    LC_BAD          = 6'b100000
  } line_check_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic logic [7:0] keyword_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "W";
      3'd1: r = "R";
      3'd2: r = "A";
      3'd3: r = "P";
      3'd4: r = "P";
      3'd5: r = "E";
      3'd6: r = "D";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] marker_char(input logic [2:0] i);
    return (i == 3'd0) ? 8'h41 : ((i == 3'd7) ? 8'h00 : 8'h30);
  endfunction

  // Fixed byte substitution applied to every payload byte that is output.
  localparam logic [7:0] SUBST [256] = '{
    8'h3D,8'h65,8'h85,8'hB3,8'h18,8'hDB,8'hE2,8'h87,8'hF1,8'h52,8'hAB,8'h63,8'h4B,8'hB5,8'hA0,8'h5F,
    8'h7D,8'h68,8'h7B,8'h9B,8'h24,8'hC2,8'h28,8'h67,8'h8A,8'hDE,8'hA4,8'h26,8'h1E,8'h03,8'hEB,8'h17,
    8'h6F,8'h34,8'h3E,8'h7A,8'h3F,8'hD2,8'hA9,8'h6A,8'h0F,8'hE9,8'h35,8'h56,8'h1F,8'hB1,8'h4D,8'h10,
    8'h78,8'hD9,8'h75,8'hF6,8'hBC,8'h41,8'h04,8'h81,8'h61,8'h06,8'hF9,8'hAD,8'hD6,8'hD5,8'h29,8'h7E,
    8'h86,8'h9E,8'h79,8'hE5,8'h05,8'hBA,8'h84,8'hCC,8'h6E,8'h27,8'h8E,8'hB0,8'h5D,8'hA8,8'hF3,8'h9F,
    8'hD0,8'hA2,8'h71,8'hB8,8'h58,8'hDD,8'h2C,8'h38,8'h99,8'h4C,8'h48,8'h07,8'h55,8'hE4,8'h53,8'h8C,
    8'h46,8'hB6,8'h2D,8'hA5,8'hAF,8'h32,8'h22,8'h40,8'hDC,8'h50,8'hC3,8'hA1,8'h25,8'h8B,8'h9C,8'h16,
    8'h60,8'h5C,8'hCF,8'hFD,8'h0C,8'h98,8'h1C,8'hD4,8'h37,8'h6D,8'h3C,8'h3A,8'h30,8'hE8,8'h6C,8'h31,
    8'h47,8'hF5,8'h33,8'hDA,8'h43,8'hC8,8'hE3,8'h5E,8'h19,8'h94,8'hEC,8'hE6,8'hA3,8'h95,8'h14,8'hE0,
    8'h9D,8'h64,8'hFA,8'h59,8'h15,8'hC5,8'h2F,8'hCA,8'hBB,8'h0B,8'hDF,8'hF2,8'h97,8'hBF,8'h0A,8'h76,
    8'hB4,8'h49,8'h44,8'h5A,8'h1D,8'hF0,8'h00,8'h96,8'h21,8'h80,8'h7F,8'h1A,8'h82,8'h39,8'h4F,8'hC1,
    8'hA7,8'hD7,8'h0D,8'hD1,8'hD8,8'hFF,8'h13,8'h93,8'h70,8'hEE,8'h5B,8'hEF,8'hBE,8'h09,8'hB9,8'h77,
    8'h72,8'hE7,8'hB2,8'h54,8'hB7,8'h2A,8'hC7,8'h73,8'h90,8'h66,8'h20,8'h0E,8'h51,8'hED,8'hF8,8'h7C,
    8'h8F,8'h2E,8'hF4,8'h12,8'hC6,8'h2B,8'h83,8'hCD,8'hAC,8'hCB,8'h3B,8'hC4,8'h4E,8'hC0,8'h69,8'h36,
    8'h62,8'h02,8'hAE,8'h88,8'hFC,8'hAA,8'h42,8'h08,8'hA6,8'h45,8'h57,8'hD3,8'h9A,8'hBD,8'hE1,8'h23,
    8'h8D,8'h92,8'h4A,8'h11,8'h89,8'h74,8'h6B,8'h91,8'hFB,8'hFE,8'hC9,8'h01,8'hEA,8'h1B,8'hF7,8'hCE
  };

endpackage

FILE: design/wrapped_text_base64_decipher.sv
// Channel | Signals                      | Item
// in      | in_valid, in_ready, in_item  | one text character, end flag
// out     | out_valid, out_ready, out_item | payload byte or end status
// The front part takes one character a cycle while the queue has room,
// updating the scanner and base64 state in that cycle; the back part
// maps bytes through the table. A four-entry queue lets the two sides
// stall apart; a character causing a byte and the status gives two output
// items. A result passes through a queue entry and the output register.
// Reset is synchronous and returns to keyword search.
module wrapped_text_base64_decipher #(
  parameter int DIGEST_BYTES = wtb64_pkg::DigestBytesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wtb64_pkg::in_item_t  in_item,
  input  logic                 in_valid,
  output logic                 in_ready,
  output wtb64_pkg::out_item_t out_item,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import wtb64_pkg::*;

  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  wtb64_front #(.DIGEST_BYTES(DIGEST_BYTES)) u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .in_valid(in_valid),
    .in_ready(in_ready), .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  wtb64_queue u_queue (
    .clk(clk), .rst(rst), .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_job(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  wtb64_back u_back (
    .clk(clk), .rst(rst), .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
  );

endmodule

FILE: design/wtb64_front.sv
module wtb64_front #(
  parameter int DIGEST_BYTES = wtb64_pkg::DigestBytesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wtb64_pkg::in_item_t  in_item,
  input  logic                 in_valid,
  output logic                 in_ready,
  output wtb64_pkg::job_t      job,
  output logic                 job_valid,
  input  logic                 job_ready
);
  import wtb64_pkg::*;

  localparam int CntW = $clog2(DIGEST_BYTES + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(DIGEST_BYTES + 1);
  localparam logic [CntW-1:0] CntDrop = CntW'(DIGEST_BYTES);

  phase_t           phase, phase_next;
  logic [2:0]       match_pos, match_pos_next;
  line_check_t      line_check, line_check_next;
  logic [11:0]      bit_buffer, bit_buffer_next;
  logic [3:0]       pending_bits, pending_bits_next;
  logic [CntW-1:0]  decoded_count, decoded_count_next;
  job_t             job_next;
  logic             go;
  logic [7:0]       c, u;
  logic             is_sp, is_hex, is_tw;
  logic [6:0]       b64v;
  logic [11:0]      shifted;
  logic [3:0]       pend_sum;
  logic [7:0]       dec_byte;
  logic             marker_ok;

  assign in_ready = job_ready;
  assign go = in_valid && in_ready;
  assign job_valid = go;
  assign job = job_next;

  assign c = in_item.text_char;
  assign u = fold_upper(c);
  assign is_sp = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  assign is_tw = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d);
  assign is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  assign marker_ok = (u == marker_char(match_pos)) && (match_pos != 3'd7);

  // Base64 alphabet value; bit 6 flags a character outside it.
  always_comb begin
    b64v = 7'h40;
    if (c inside {[8'h41:8'h5a]}) begin
      b64v = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7a]}) begin
      b64v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      b64v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      b64v = 7'd62;
    end else if (c == 8'h2f) begin
      b64v = 7'd63;
    end
  end

  assign shifted = {bit_buffer[5:0], b64v[5:0]};
  assign pend_sum = pending_bits + 4'd6;
  assign dec_byte = 8'(shifted >> (pend_sum - 4'd8));

  // Scanner and decoder state update for one item.
  always_comb begin
    phase_next = phase;
    match_pos_next = match_pos;
    line_check_next = line_check;
    bit_buffer_next = bit_buffer;
    pending_bits_next = pending_bits;
    decoded_count_next = decoded_count;
    job_next = '0;
    case (phase)
      PH_KEYWORD: begin
        if (match_pos != 3'd7 && u == keyword_char(match_pos)) begin
          match_pos_next = match_pos + 3'd1;
          if (match_pos == 3'd6) begin
            phase_next = PH_SPACE;
            match_pos_next = '0;
          end
        end else begin
          match_pos_next = (u == 8'h57) ? 3'd1 : 3'd0;
        end
      end
      PH_SPACE, PH_MARKER: begin
        if (phase == PH_SPACE && is_sp) begin
          phase_next = PH_SPACE;
        end else if ((phase == PH_SPACE) ? (u == 8'h41) : marker_ok) begin
          phase_next = PH_MARKER;
          match_pos_next = (phase == PH_SPACE) ? 3'd1 : match_pos + 3'd1;
          if (phase == PH_MARKER && match_pos == 3'd6) begin
            phase_next = PH_LINES;
            match_pos_next = '0;
            line_check_next = LC_FIRST_EMPTY;
          end
        end else begin
          phase_next = PH_FAILED;
          if (phase == PH_SPACE) begin
            match_pos_next = '0;
          end
        end
      end
      PH_LINES: begin
        if (c == 8'h0a) begin
          if (line_check == LC_SECOND || line_check == LC_TRAIL) begin
            phase_next = PH_DECODE;
            bit_buffer_next = '0;
            pending_bits_next = '0;
            decoded_count_next = '0;
          end
          line_check_next = LC_FIRST_EMPTY;
        end else begin
          case (line_check)
            LC_FIRST_EMPTY:  line_check_next = is_hex ? LC_FIRST : LC_BAD;
            LC_FIRST:        line_check_next = is_hex ? LC_FIRST :
                                               ((c == 8'h20) ? LC_SECOND_EMPTY : LC_BAD);
            LC_SECOND_EMPTY: line_check_next = is_hex ? LC_SECOND : LC_BAD;
            LC_SECOND:       line_check_next = is_hex ? LC_SECOND :
                                               (is_tw ? LC_TRAIL : LC_BAD);
            LC_TRAIL:        line_check_next = is_tw ? LC_TRAIL : LC_BAD;
            default:         line_check_next = LC_BAD;
          endcase
        end
      end
      PH_DECODE: begin
        if (c == 8'h3d) begin
          phase_next = PH_DONE;
        end else if (!b64v[6]) begin
          if (pend_sum >= 4'd8) begin
            pending_bits_next = pend_sum - 4'd8;
            bit_buffer_next = shifted & ((12'd1 << (pend_sum - 4'd8)) - 12'd1);
            job_next.has_byte = (decoded_count >= CntDrop);
            job_next.raw_byte = dec_byte;
            if (decoded_count < CntSat) begin
              decoded_count_next = decoded_count + 1'b1;
            end
          end else begin
            pending_bits_next = pend_sum;
            bit_buffer_next = shifted;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    if (in_item.end_of_text) begin
      job_next.has_end = 1'b1;
      if (phase_next == PH_LINES) begin
        job_next.end_status = ST_NO_TERM;
      end else if (phase_next == PH_DECODE || phase_next == PH_DONE) begin
        job_next.end_status = (decoded_count_next < CntSat) ? ST_SHORT : ST_OK;
      end else begin
        job_next.end_status = ST_NO_MARKER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (go && in_item.end_of_text)) begin
      phase <= PH_KEYWORD;
      match_pos <= '0;
      line_check <= LC_FIRST_EMPTY;
      bit_buffer <= '0;
      pending_bits <= '0;
      decoded_count <= '0;
    end else if (go) begin
      phase <= phase_next;
      match_pos <= match_pos_next;
      line_check <= line_check_next;
      bit_buffer <= bit_buffer_next;
      pending_bits <= pending_bits_next;
      decoded_count <= decoded_count_next;
    end
  end

endmodule

FILE: design/wtb64_queue.sv
module wtb64_queue (
  input  logic             clk,
  input  logic             rst,
  input  wtb64_pkg::job_t  wr_job,
  input  logic             wr_valid,
  output logic             wr_ready,
  output wtb64_pkg::job_t  rd_job,
  output logic             rd_valid,
  input  logic             rd_ready
);
  import wtb64_pkg::*;

  localparam int AW = $clog2(QueueDepth);

  job_t          mem [QueueDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign wr_ready = (count != (AW+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_job = mem[rd_ptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // Small register queue; entries are only read once written.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

FILE: design/wtb64_back.sv
module wtb64_back (
  input  logic                 clk,
  input  logic                 rst,
  input  wtb64_pkg::job_t      job,
  input  logic                 job_valid,
  output logic                 job_ready,
  output wtb64_pkg::out_item_t out_item,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import wtb64_pkg::*;

  logic      byte_done;
  logic      need_byte, need_end;
  logic      emit;
  out_item_t item_next;
  logic      last_of_job;

  // A job gives a byte, then the status, each when present.
  assign need_byte = job_valid && job.has_byte && !byte_done;
  assign need_end = job_valid && job.has_end;
  assign emit = (need_byte || need_end) && (!out_valid || out_ready);
  assign last_of_job = !(need_byte && need_end);
  assign job_ready = job_valid && (!(need_byte || need_end) || (emit && last_of_job));

  always_comb begin
    item_next = '0;
    if (need_byte) begin
      item_next.out_byte = SUBST[job.raw_byte];
      item_next.item_kind = KIND_BYTE;
    end else begin
      item_next.item_kind = KIND_STATUS;
      item_next.end_status = job.end_status;
      item_next.final_item = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_done <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_ready) begin
        byte_done <= 1'b0;
      end else if (emit && need_byte) begin
        byte_done <= 1'b1;
      end
    end
  end

endmodule
